// File: sv/rfe_pkg.sv
// Shared types and constants for the record field extractor.
`default_nettype none
package rfe_pkg;

    localparam int DEF_MAX_TAG_DIGITS = 10;
    localparam int DEF_QUEUE_DEPTH    = 4;

    localparam int TAG_W  = 31;
    localparam int BYTE_W = 8;

    // Configuration register indexes
    localparam logic CFG_TARGET_TAG = 1'b0;
    localparam logic CFG_UNESCAPE   = 1'b1;

    // Scan phases
    localparam logic [1:0] PH_TAG   = 2'd0;
    localparam logic [1:0] PH_VALUE = 2'd1;
    localparam logic [1:0] PH_SKIP  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic [BYTE_W-1:0] CHR_AMP  = 8'h26;
    localparam logic [BYTE_W-1:0] CHR_EQ   = 8'h3D;
    localparam logic [BYTE_W-1:0] CHR_BSL  = 8'h5C;
    localparam logic [BYTE_W-1:0] CHR_A    = 8'h61;
    localparam logic [BYTE_W-1:0] CHR_B    = 8'h62;
    localparam logic [BYTE_W-1:0] CHR_N    = 8'h6E;
    localparam logic [BYTE_W-1:0] CHR_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CHR_0    = 8'h30;
    localparam logic [BYTE_W-1:0] CHR_9    = 8'h39;

    typedef struct packed {
        logic [BYTE_W-1:0] value_byte;
        logic              byte_valid;
        logic              last_result;
        logic              found;
    } t_result;

    // All results caused by one input byte: one or two
    typedef struct packed {
        t_result res0;
        t_result res1;
        logic    two;
    } t_packet;

endpackage
`default_nettype wire

// File: sv/record_field_extractor_unit.sv
// Top level of the record field extractor: parser front end and result queue.
//
//  channel   direction  transaction when        payload
//  input     in         push & !full            i_data_byte, i_end_of_record
//  result    out        pop & !empty            o_value_byte, o_byte_valid,
//                                               o_last_result, o_found
//  config    in         i_cfg_we                i_cfg_index, i_cfg_data
//
// One byte is taken per cycle while full is low; its state is updated in that cycle.
// A byte causes zero, one or two results; they reach the result side in the cycle after.
// A byte with two results occupies the result side for two pops, so a steady run of
// such bytes waits on pops to drain entries once the QUEUE_DEPTH packet queue fills.
// full depends only on queue occupancy; reset is synchronous and empties the queue.
`default_nettype none
module record_field_extractor_unit #(
    parameter int MAX_TAG_DIGITS = rfe_pkg::DEF_MAX_TAG_DIGITS,
    parameter int QUEUE_DEPTH    = rfe_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_index,
    input  wire logic [rfe_pkg::TAG_W-1:0]  i_cfg_data,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [rfe_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic                       i_end_of_record,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [rfe_pkg::BYTE_W-1:0]      o_value_byte,
    output logic                            o_byte_valid,
    output logic                            o_last_result,
    output logic                            o_found
);
    import rfe_pkg::*;

    logic    accept;
    logic    pkt_push;
    t_packet pkt;
    t_result res;

    assign accept = push && !full;

    rfe_front #(
        .MAX_TAG_DIGITS(MAX_TAG_DIGITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_end_of_record(i_end_of_record),
        .o_pkt_push     (pkt_push),
        .o_pkt          (pkt)
    );

    rfe_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (pkt_push),
        .i_pkt  (pkt),
        .o_full (full),
        .o_empty(empty),
        .i_pop  (pop),
        .o_res  (res)
    );

    assign o_value_byte  = res.value_byte;
    assign o_byte_valid  = res.byte_valid;
    assign o_last_result = res.last_result;
    assign o_found       = res.found;

endmodule
`default_nettype wire

// File: sv/rfe_front.sv
// Front end: tag parser, value scanner and unescaper; builds at most one packet per byte.
`default_nettype none
module rfe_front #(
    parameter int MAX_TAG_DIGITS = rfe_pkg::DEF_MAX_TAG_DIGITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_index,
    input  wire logic [rfe_pkg::TAG_W-1:0] i_cfg_data,
    input  wire logic                      i_accept,
    input  wire logic [rfe_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic                      i_end_of_record,
    output logic                           o_pkt_push,
    output rfe_pkg::t_packet               o_pkt
);
    import rfe_pkg::*;

    localparam int CNT_W = $clog2(MAX_TAG_DIGITS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TAG_DIGITS);

    logic [TAG_W-1:0] r_target_tag;
    logic             r_unescape;
    logic [1:0]       r_phase,    n_phase;
    logic [TAG_W-1:0] r_acc,      n_acc;
    logic [CNT_W-1:0] r_cnt,      n_cnt;
    logic             r_inv,      n_inv;
    logic             r_pend,     n_pend;
    logic             r_nonempty, n_nonempty;

    logic [BYTE_W-1:0] by0, by1;
    logic [1:0]        nb;
    logic              close;
    logic              fnd;
    logic              is_digit;
    logic [TAG_W+3:0]  prod;
    logic [BYTE_W-1:0] mapped;
    logic              map_hit;
    logic              plain;
    logic [BYTE_W-1:0] b;

    assign b        = i_data_byte;
    assign is_digit = (b >= CHR_0) && (b <= CHR_9);
    // acc*10 + digit as shifts and adds
    assign prod = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {31'd0, b[3:0]};

    always_comb begin
        map_hit = 1'b1;
        unique case (b)
            CHR_BSL: mapped = CHR_BSL;
            CHR_A:   mapped = CHR_EQ;
            CHR_B:   mapped = CHR_AMP;
            CHR_N:   mapped = CHR_LF;
            default: begin
                mapped  = CHR_BSL;
                map_hit = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_inv      = r_inv;
        n_pend     = r_pend;
        n_nonempty = r_nonempty;
        by0        = '0;
        by1        = '0;
        nb         = 2'd0;
        close      = 1'b0;
        plain      = 1'b1;

        unique case (r_phase)
            PH_TAG: begin
                if (is_digit) begin
                    if (!r_inv) begin
                        if (r_cnt >= CNT_MAX || (r_cnt != '0 && r_acc == '0)) begin
                            n_inv = 1'b1;
                        end else if (prod[TAG_W+3:TAG_W] != '0) begin
                            n_inv = 1'b1;
                        end else begin
                            n_acc = prod[TAG_W-1:0];
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                end else if (b == CHR_EQ) begin
                    if (!r_inv && r_cnt != '0 && r_acc == r_target_tag) begin
                        n_phase    = PH_VALUE;
                        n_pend     = 1'b0;
                        n_nonempty = 1'b0;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end else if (b == CHR_AMP) begin
                    n_acc = '0;
                    n_cnt = '0;
                    n_inv = 1'b0;
                end else begin
                    n_inv = 1'b1;
                end
            end
            PH_SKIP: begin
                if (b == CHR_AMP) begin
                    n_phase = PH_TAG;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_inv   = 1'b0;
                end
            end
            PH_VALUE: begin
                if (r_pend) begin
                    n_pend = 1'b0;
                    by0    = mapped;
                    nb     = 2'd1;
                    plain  = !map_hit;
                end
                if (plain) begin
                    if (b == CHR_AMP) begin
                        close = 1'b1;
                    end else if (r_unescape && b == CHR_BSL) begin
                        n_pend = 1'b1;
                    end else if (nb == 2'd0) begin
                        by0 = b;
                        nb  = 2'd1;
                    end else begin
                        by1 = b;
                        nb  = 2'd2;
                    end
                end
            end
            default: begin
            end
        endcase

        // record end closes an open search; a dangling backslash goes out as is
        if (i_end_of_record && r_phase != PH_DONE) begin
            if (n_phase == PH_VALUE && n_pend) begin
                if (nb == 2'd0) begin
                    by0 = CHR_BSL;
                    nb  = 2'd1;
                end else begin
                    by1 = CHR_BSL;
                    nb  = 2'd2;
                end
                n_pend = 1'b0;
            end
            close = 1'b1;
        end

        if (nb != 2'd0) n_nonempty = 1'b1;
        fnd = (n_phase == PH_VALUE) ? n_nonempty : 1'b0;

        if (close) n_phase = PH_DONE;

        if (i_end_of_record) begin
            n_phase    = PH_TAG;
            n_acc      = '0;
            n_cnt      = '0;
            n_inv      = 1'b0;
            n_pend     = 1'b0;
            n_nonempty = 1'b0;
        end
    end

    // Packet assembly: the last byte of a closing step rides on the closing result
    always_comb begin
        o_pkt            = '0;
        o_pkt.two        = (nb == 2'd2);
        o_pkt_push       = i_accept && (close || nb != 2'd0);
        o_pkt.res0.value_byte = by0;
        o_pkt.res0.byte_valid = (nb != 2'd0);
        o_pkt.res1.value_byte = by1;
        o_pkt.res1.byte_valid = (nb == 2'd2);
        if (close) begin
            if (nb == 2'd2) begin
                o_pkt.res1.last_result = 1'b1;
                o_pkt.res1.found       = fnd;
            end else begin
                o_pkt.res0.last_result = 1'b1;
                o_pkt.res0.found       = fnd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_tag <= '0;
            r_unescape   <= 1'b1;
            r_phase      <= PH_TAG;
            r_acc        <= '0;
            r_cnt        <= '0;
            r_inv        <= 1'b0;
            r_pend       <= 1'b0;
            r_nonempty   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TARGET_TAG: r_target_tag <= i_cfg_data;
                    CFG_UNESCAPE:   r_unescape   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_accept) begin
                r_phase    <= n_phase;
                r_acc      <= n_acc;
                r_cnt      <= n_cnt;
                r_inv      <= n_inv;
                r_pend     <= n_pend;
                r_nonempty <= n_nonempty;
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/rfe_queue.sv
// Back end: packet queue that hands out the results one per transaction.
`default_nettype none
module rfe_queue #(
    parameter int QUEUE_DEPTH = rfe_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire rfe_pkg::t_packet i_pkt,
    output logic                  o_full,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output rfe_pkg::t_result      o_res
);
    import rfe_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_packet          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             r_sub;
    t_packet          head;
    logic             deq;

    assign head    = r_mem[r_rd];
    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_sub ? head.res1 : head.res0;
    // second half of a two-result packet keeps the entry one more transaction
    assign deq     = i_pop && !o_empty && (r_sub || !head.two);

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_pkt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
            r_sub <= 1'b0;
        end else begin
            if (i_push) r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            if (deq)    r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            if (i_pop && !o_empty) r_sub <= !deq;
            unique case ({i_push, deq})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: sv/rfe_checker.sv
// Port-level checks for the record field extractor, bound to the top level.
`default_nettype none
module rfe_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] o_value_byte,
    input wire logic       o_byte_valid,
    input wire logic       o_last_result,
    input wire logic       o_found
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_value_byte) && $stable(o_byte_valid)
                              && $stable(o_last_result) && $stable(o_found)))
        else $error("waiting result changed without a transaction");

    a_blank_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_byte_valid) |-> (o_value_byte == 8'h00 && o_last_result))
        else $error("result without a byte must be a zero closing result");

    a_found_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_found) |-> o_last_result)
        else $error("found flag outside the closing result");

endmodule

bind record_field_extractor_unit rfe_checker u_rfe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pop          (pop),
    .o_value_byte (o_value_byte),
    .o_byte_valid (o_byte_valid),
    .o_last_result(o_last_result),
    .o_found      (o_found)
);
`default_nettype wire
